@@ sv/epdt_pkg.sv @@
// shared constants, payload types and control structs for the edge point table
package epdt_pkg;

  localparam int unsigned SRC_POINTS     = 1024;
  localparam int unsigned EDGE_SLOTS     = 8;
  localparam int unsigned BUCKET_ENTRIES = EDGE_SLOTS / 2;
  localparam int unsigned ROW_AW         = $clog2(SRC_POINTS);

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PT_W     = 10;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned ID_W     = 20;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CREATED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PT_W-1:0]   point_a;
    logic [PT_W-1:0]   point_b;
    logic [CNT_W-1:0]  seg_count;
    logic [POS_W-1:0]  seg_pos;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     new_id;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [PT_W-1:0] upper;
    logic [ID_W-1:0] base;
  } entry_t;

  typedef entry_t [BUCKET_ENTRIES-1:0] row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef struct packed {
    logic sweep;
    logic accept;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_busy;
    logic in_clear;
  } dp_status_t;

endpackage

@@ sv/epdt_ram.sv @@
// generic single write, single registered read port ram
module epdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/epdt_ctrl.sv @@
// controller state machine: table sweep, accept, evaluate and result hand-off
module epdt_ctrl
  import epdt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.in_clear ? ST_CLEAR : ST_EVAL;
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EVAL || state_q == ST_CLEAR))
    else $error("accepted item did not move to evaluate or clear");

  a_sweep_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && status_i.sweep_last) |=> state_q == ST_IDLE)
    else $error("start-up sweep did not end in idle");

  a_eval_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && status_i.out_busy) |=> state_q == ST_EVAL)
    else $error("result committed over a waiting result");

endmodule

@@ sv/epdt_dpath.sv @@
// datapath: item registers, bucket scan, table memory, id counter and result register
module epdt_dpath
  import epdt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  in_item_t        in_item_i,
  input  logic [ID_W-1:0] start_id_i,
  input  ctl_cmd_t        cmd_i,
  output dp_status_t      status_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output out_item_t       out_item_o
);

  // item registers
  logic [MODE_W-1:0] mode_q;
  logic [PT_W-1:0]   lower_q, upper_q;
  logic              asc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  pos_q;

  logic [PT_W-1:0]   lower_in, upper_in;
  logic              asc_in;

  logic [ROW_AW-1:0] sweep_q;
  logic              sweep_last;

  logic [ID_W-1:0]   next_point_q, next_point_d;
  out_item_t         out_q, res;
  logic              out_valid_q;

  row_t                      row_rd, row_new;
  logic [BUCKET_ENTRIES-1:0] sel;
  logic                      found, hit, empty, in_range, make;
  logic [ID_W-1:0]           hit_base, step;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  assign asc_in   = in_item_i.point_a < in_item_i.point_b;
  assign lower_in = asc_in ? in_item_i.point_a : in_item_i.point_b;
  assign upper_in = asc_in ? in_item_i.point_b : in_item_i.point_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= in_item_i.mode;
      lower_q <= lower_in;
      upper_q <= upper_in;
      asc_q   <= asc_in;
      cnt_q   <= in_item_i.seg_count;
      pos_q   <= in_item_i.seg_pos;
    end
  end

  assign sweep_last = sweep_q == ROW_AW'(SRC_POINTS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
    end
  end

  // entries are claimed in order, so the scan stops at the first empty or matching one
  assign row_rd = row_t'(ram_rdata);

  always_comb begin
    found    = 1'b0;
    hit      = 1'b0;
    empty    = 1'b0;
    sel      = '0;
    hit_base = '0;
    for (int i = 0; i < BUCKET_ENTRIES; i++) begin
      if (!found) begin
        if (!row_rd[i].valid) begin
          found  = 1'b1;
          empty  = 1'b1;
          sel[i] = 1'b1;
        end else if (row_rd[i].upper == upper_q) begin
          found    = 1'b1;
          hit      = 1'b1;
          sel[i]   = 1'b1;
          hit_base = row_rd[i].base;
        end
      end
    end
  end

  assign in_range = 32'(lower_q) < SRC_POINTS;
  assign make     = mode_q == MODE_FIND && in_range && !hit && empty;
  assign step     = (cnt_q == '0) ? ID_W'(1) : ID_W'(cnt_q);

  always_comb begin
    for (int i = 0; i < BUCKET_ENTRIES; i++) begin
      row_new[i] = row_rd[i];
      if (sel[i]) begin
        row_new[i].valid = 1'b1;
        row_new[i].upper = upper_q;
        row_new[i].base  = next_point_q;
      end
    end
  end

  always_comb begin
    res          = '{new_id: '0, status: STATUS_MISSING};
    next_point_d = next_point_q;
    case (mode_q)
      MODE_FIND: begin
        res.status = STATUS_FULL;
        if (in_range && hit) begin
          res = '{new_id: hit_base, status: STATUS_FOUND};
        end else if (make) begin
          res          = '{new_id: next_point_q, status: STATUS_CREATED};
          next_point_d = next_point_q + step;
        end
      end
      MODE_GET: begin
        if (in_range && hit) begin
          res.status = STATUS_FOUND;
          if (asc_q) begin
            res.new_id = hit_base + ID_W'(cnt_q) - ID_W'(1) - ID_W'(pos_q);
          end else begin
            res.new_id = hit_base + ID_W'(pos_q);
          end
        end
      end
      MODE_CLEAR: begin
        res.status   = STATUS_FOUND;
        next_point_d = start_id_i;
      end
      default: begin
        res.status = STATUS_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_point_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        next_point_q <= next_point_d;
        out_valid_q  <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign ram_we    = cmd_i.sweep || (cmd_i.commit && make);
  assign ram_waddr = cmd_i.sweep ? sweep_q : ROW_AW'(lower_q);
  assign ram_wdata = cmd_i.sweep ? '0 : ROW_W'(row_new);

  epdt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SRC_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (ROW_AW'(lower_in)),
    .rdata_o (ram_rdata)
  );

  assign status_o.sweep_last = sweep_last;
  assign status_o.out_busy   = out_valid_q && out_stall_i;
  assign status_o.in_clear   = in_item_i.mode == MODE_CLEAR;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_commit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not leave a result waiting");

  a_counter_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(next_point_q))
    else $error("id counter moved without a commit");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed or was dropped");

endmodule

@@ sv/edge_point_dedup_table_core.sv @@
// edge point table: find/make, get and clear of per-edge point id runs
// find or get: the bucket row read is registered on the input transfer, then the evaluate
//   state loads the result register, waiting while a stalled result is held
// a new find or get item is accepted only after the last one has loaded the result register
// clear: sweeps all SRC_POINTS rows, one a cycle, then loads its result like a find or get
// reset: all SRC_POINTS rows swept with in_stall_o high, counter and start id zero
module edge_point_dedup_table_core
  import epdt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  // start id register
  input  logic            cfg_we_i,
  input  logic [ID_W-1:0] cfg_data_i
);

  // start id loaded into the counter by a clear
  logic [ID_W-1:0] start_id_q;

  ctl_cmd_t   cmd;
  dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_id_q <= '0;
    end else if (cfg_we_i) begin
      start_id_q <= cfg_data_i;
    end
  end

  // controller: sweeps the table after reset and on clear, accepts one item
  // at a time and commits its result once the result register is free
  epdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: the bucket row is read on the input transfer, all entries of
  // the row are compared in parallel, the updated row is written back on a commit that creates an entry
  epdt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .start_id_i  (start_id_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sim/tb_edge_point_dedup_table_core.sv @@
// testbench for the edge point table core: directed table, then random find/get/clear/ignored traffic
`timescale 1ns / 1ps
module tb_edge_point_dedup_table_core;
  import epdt_pkg::*;

  // mode code with no operation behind it, answered as not found
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned PHASE_COUNT  = 4;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ERR_SHOWN    = 10;
  localparam int unsigned LIMIT_NS     = 2_000_000;
  localparam int unsigned RESET_CYCLES = 4;

  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [PT_W-1:0] PT_MAX = '1;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_item_t        in_item_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_item_t       out_item_o;
  logic            cfg_we_i    = 1'b0;
  logic [ID_W-1:0] cfg_data_i  = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // mirror of the edge table and the id counter
  bit              tbl_used  [SRC_POINTS][BUCKET_ENTRIES];
  logic [PT_W-1:0] tbl_upper [SRC_POINTS][BUCKET_ENTRIES];
  logic [ID_W-1:0] tbl_base  [SRC_POINTS][BUCKET_ENTRIES];
  logic [ID_W-1:0] next_id;
  logic [ID_W-1:0] start_id;

  out_item_t   pending_q[$];
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned status_seen [4];

  // directed requests, with a hand-typed answer where it is obvious
  in_item_t  dir_req[$];
  bit        dir_typed[$];
  out_item_t dir_want[$];

  edge_point_dedup_table_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void clear_edge_table();
    for (int r = 0; r < SRC_POINTS; r++) begin
      for (int s = 0; s < BUCKET_ENTRIES; s++) begin
        tbl_used[r][s] = 1'b0;
      end
    end
  endfunction

  // works out the answer to one request and updates the mirrored table
  function automatic out_item_t predict_edge_point(in_item_t req);
    out_item_t       res;
    logic [PT_W-1:0] lower;
    logic [PT_W-1:0] upper;
    int              slot;
    bit              hit;
    res.new_id = '0;
    res.status = STATUS_MISSING;
    lower = (req.point_a < req.point_b) ? req.point_a : req.point_b;
    upper = (req.point_a < req.point_b) ? req.point_b : req.point_a;
    slot  = -1;
    hit   = 1'b0;
    // scan stops at the first match or the first empty entry
    if (lower < SRC_POINTS) begin
      for (int s = 0; s < BUCKET_ENTRIES; s++) begin
        if (slot < 0) begin
          if (!tbl_used[lower][s]) begin
            slot = s;
          end else if (tbl_upper[lower][s] == upper) begin
            slot = s;
            hit  = 1'b1;
          end
        end
      end
    end
    case (req.mode)
      MODE_FIND: begin
        if (hit) begin
          res.new_id = tbl_base[lower][slot];
          res.status = STATUS_FOUND;
        end else if (slot >= 0) begin
          tbl_used[lower][slot]  = 1'b1;
          tbl_upper[lower][slot] = upper;
          tbl_base[lower][slot]  = next_id;
          res.new_id = next_id;
          res.status = STATUS_CREATED;
          // a zero split count still makes one point
          next_id = next_id + ((req.seg_count == '0) ? ID_W'(1) : ID_W'(req.seg_count));
        end else begin
          res.status = STATUS_FULL;
        end
      end
      MODE_GET: begin
        if (hit) begin
          // ascending endpoints walk the run from its far end
          if (req.point_a < req.point_b) begin
            res.new_id = tbl_base[lower][slot] + ID_W'(req.seg_count) - ID_W'(1)
                         - ID_W'(req.seg_pos);
          end else begin
            res.new_id = tbl_base[lower][slot] + ID_W'(req.seg_pos);
          end
          res.status = STATUS_FOUND;
        end
      end
      MODE_CLEAR: begin
        clear_edge_table();
        next_id    = start_id;
        res.status = STATUS_FOUND;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic in_item_t make_request(logic [MODE_W-1:0] mode, int unsigned a,
                                            int unsigned b, int unsigned cnt,
                                            int unsigned pos);
    in_item_t req;
    req.mode      = mode;
    req.point_a   = PT_W'(a);
    req.point_b   = PT_W'(b);
    req.seg_count = CNT_W'(cnt);
    req.seg_pos   = POS_W'(pos);
    return req;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] mode, int unsigned a, int unsigned b,
                                  int unsigned cnt, int unsigned pos, bit typed,
                                  logic [STATUS_W-1:0] want_status);
    out_item_t want;
    want.new_id = '0;
    want.status = want_status;
    dir_req.push_back(make_request(mode, a, b, cnt, pos));
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endfunction

  // mostly a few crowded buckets so hits and full buckets are common
  function automatic in_item_t rand_edge_request();
    in_item_t        req;
    int unsigned     sel;
    int unsigned     pick;
    logic [PT_W-1:0] swap;
    sel  = $urandom_range(99);
    pick = $urandom_range(9);
    req.seg_count = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(31))
                                             : CNT_W'($urandom_range(16, 1));
    req.seg_pos   = POS_W'($urandom_range(15));
    if (pick < 7) begin
      req.point_a = PT_W'($urandom_range(7));
      req.point_b = PT_W'($urandom_range(11));
    end else if (pick == 7) begin
      req.point_a = $urandom_range(1) ? PT_MAX : '0;
      req.point_b = $urandom_range(1) ? PT_MAX : '0;
    end else begin
      req.point_a = PT_W'($urandom_range(PT_MAX));
      req.point_b = PT_W'($urandom_range(PT_MAX));
    end
    if ($urandom_range(1) == 1) begin
      swap        = req.point_a;
      req.point_a = req.point_b;
      req.point_b = swap;
    end
    if (sel < 2) begin
      req.mode = MODE_CLEAR;
    end else if (sel < 4) begin
      req.mode = MODE_IGNORED;
    end else if (sel < 50) begin
      req.mode = MODE_FIND;
    end else begin
      req.mode = MODE_GET;
    end
    return req;
  endfunction

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    n_errors++;
    if (n_errors <= ERR_SHOWN) begin
      $display("%0t: %s: expected id %h status %0d, got id %h status %0d", $time, what,
               want.new_id, want.status, got.new_id, got.status);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(in_item_t req, bit typed, out_item_t typed_want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted = predict_edge_point(req);
    pending_q.push_back(typed ? typed_want : predicted);
    n_accepted++;
    @(negedge clk_i);
  endtask

  task automatic write_start_id(logic [ID_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    start_id = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_q.size() == 0) begin
        want = '0;
        note_mismatch("result with nothing pending", want, out_item_o);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        status_seen[out_item_o.status]++;
        if (out_item_o.new_id !== want.new_id || out_item_o.status !== want.status) begin
          note_mismatch("wrong result", want, out_item_o);
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("run did not finish in time, %0d results still pending", pending_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] phase_start;
    int unsigned     per_phase;
    out_item_t       no_want;
    clear_edge_table();
    next_id   = '0;
    start_id  = '0;
    no_want   = '0;
    per_phase = RANDOM_ITEMS / PHASE_COUNT;

    // fill a bucket, hit it both ways round, overflow it, then clear
    add_row(MODE_GET,     5,    9,    3,  0, 1'b1, STATUS_MISSING);
    add_row(MODE_FIND,    5,    9,    3,  0, 1'b1, STATUS_CREATED);
    add_row(MODE_FIND,    9,    5,    7,  0, 1'b1, STATUS_FOUND);
    add_row(MODE_GET,     5,    9,    3,  0, 1'b0, STATUS_FOUND);
    add_row(MODE_GET,     9,    5,    3,  2, 1'b0, STATUS_FOUND);
    add_row(MODE_FIND,    5,    10,   0,  0, 1'b0, STATUS_CREATED);
    add_row(MODE_FIND,    5,    11,   16, 0, 1'b0, STATUS_CREATED);
    add_row(MODE_FIND,    5,    12,   1,  0, 1'b0, STATUS_CREATED);
    add_row(MODE_FIND,    5,    13,   4,  0, 1'b1, STATUS_FULL);
    add_row(MODE_GET,     13,   5,    4,  1, 1'b1, STATUS_MISSING);
    add_row(MODE_GET,     5,    10,   0,  15, 1'b0, STATUS_FOUND);
    add_row(MODE_FIND,    1023, 1023, 16, 0, 1'b0, STATUS_CREATED);
    add_row(MODE_GET,     1023, 1023, 31, 15, 1'b0, STATUS_FOUND);
    add_row(MODE_FIND,    0,    0,    31, 0, 1'b0, STATUS_CREATED);
    add_row(MODE_FIND,    0,    1023, 5,  0, 1'b0, STATUS_CREATED);
    add_row(MODE_GET,     0,    1023, 31, 15, 1'b0, STATUS_FOUND);
    add_row(MODE_GET,     1023, 0,    5,  15, 1'b0, STATUS_FOUND);
    add_row(MODE_IGNORED, 0,    0,    0,  0, 1'b1, STATUS_MISSING);
    add_row(MODE_IGNORED, 1023, 1023, 31, 15, 1'b1, STATUS_MISSING);
    add_row(MODE_CLEAR,   0,    0,    0,  0, 1'b1, STATUS_FOUND);
    add_row(MODE_GET,     5,    9,    3,  0, 1'b1, STATUS_MISSING);
    // counter now starts just below the wrap
    add_row(MODE_FIND,    9,    5,    16, 0, 1'b0, STATUS_CREATED);
    add_row(MODE_FIND,    7,    8,    1,  0, 1'b0, STATUS_CREATED);
    add_row(MODE_GET,     9,    5,    16, 15, 1'b0, STATUS_FOUND);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          phase_start    = ID_MAX - ID_W'(7);
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 0;
          phase_start    = '0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 50;
          phase_start    = ID_MAX;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
          phase_start    = ID_W'($urandom_range(ID_MAX));
        end
      endcase
      write_start_id(phase_start);
      if (p == 0) begin
        for (int i = 0; i < dir_req.size(); i++) begin
          send_request(dir_req[i], dir_typed[i], dir_want[i]);
        end
      end else begin
        // load the new start id straight away
        send_request(make_request(MODE_CLEAR, 0, 0, 0, 0), 1'b0, no_want);
      end
      for (int i = 0; i < per_phase; i++) begin
        send_request(rand_edge_request(), 1'b0, no_want);
      end
      wait_drained();
    end

    $display("%0d requests (%0d directed) over %0d start id settings, %0d results checked",
             n_accepted, dir_req.size(), PHASE_COUNT, n_checked);
    $display("answers: %0d found/cleared, %0d created, %0d bucket full, %0d not found",
             status_seen[STATUS_FOUND], status_seen[STATUS_CREATED],
             status_seen[STATUS_FULL], status_seen[STATUS_MISSING]);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
